### rtl/nts_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nts_pkg
// Shared types, constants and helpers of the nixie transition sequencer.
// ---------------------------------------------------------------------------
package nts_pkg;

    localparam int FADE_STEPS       = 64;
    localparam int ROLL_INTERVAL_MS = 50;
    localparam int US_PER_MS        = 1000;

    localparam int DUR_W    = 16;
    localparam int DIGIT_W  = 5;
    localparam int DOT_W    = 2;
    localparam int WAIT_W   = 26;
    localparam int CNT_W    = $clog2(FADE_STEPS + 1);
    localparam int SLICE_W  = $clog2((((2 ** DUR_W) - 1) * US_PER_MS) / FADE_STEPS + 1);
    localparam int PROD_W   = SLICE_W + CNT_W;
    localparam int MAX_CMDS = 4;
    localparam int NUM_W    = $clog2(MAX_CMDS + 1);
    localparam int IDX_W    = $clog2(MAX_CMDS);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic signed [DIGIT_W-1:0] DIGIT_NONE = -5'sd1;
    localparam logic signed [DIGIT_W-1:0] DIGIT_MAX  = 5'sd9;
    localparam logic signed [DOT_W-1:0]   DOT_NONE   = -2'sd1;
    localparam logic signed [DOT_W-1:0]   DOT_MAX    = 2'sd1;

    localparam logic [WAIT_W-1:0] ROLL_WAIT_US = WAIT_W'(ROLL_INTERVAL_MS * US_PER_MS);

    typedef enum logic
    {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

    typedef enum logic [2:0]
    {
        PAT_OFF        = 3'd0,
        PAT_SHOW       = 3'd1,
        PAT_FADE_IN    = 3'd2,
        PAT_FADE_OUT   = 3'd3,
        PAT_CHANGE     = 3'd4,
        PAT_ROLL       = 3'd5,
        PAT_FROM_CLOUD = 3'd6,
        PAT_INTO_CLOUD = 3'd7
    } pattern_t;

    typedef struct packed
    {
        logic                      target_all;
        logic signed [DIGIT_W-1:0] digit;
        logic signed [DOT_W-1:0]   dot_sel;
        logic                      light;
        logic [WAIT_W-1:0]         wait_us;
    } cmd_t;

    typedef struct packed
    {
        cmd_t [MAX_CMDS-1:0] cmds;
        logic [NUM_W-1:0]    count;
        logic                busy;
    } batch_t;

    function automatic cmd_t make_cmd(input logic all,
                                      input logic signed [DIGIT_W-1:0] dg,
                                      input logic signed [DOT_W-1:0] dt,
                                      input logic on,
                                      input logic [WAIT_W-1:0] wt);
        cmd_t c;
        c.target_all = all;
        c.digit      = all ? DIGIT_NONE : dg;
        c.dot_sel    = all ? DOT_NONE : dt;
        c.light      = on;
        c.wait_us    = wt;
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/nts_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nts_front
// Accepts start and tick beats, advances the transition state and builds
// the batch of cathode commands that each beat causes.
// ---------------------------------------------------------------------------
module nts_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [nts_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           q_ready,
    output logic                                push,
    output nts_pkg::batch_t                     batch
);
    import nts_pkg::*;

    pattern_t                  pattern_reg, pattern_next;
    logic                      running_reg, running_next;
    logic signed [DIGIT_W-1:0] shown_digit_reg, shown_digit_next;
    logic signed [DIGIT_W-1:0] target_digit_reg, target_digit_next;
    logic signed [DOT_W-1:0]   shown_dot_reg, shown_dot_next;
    logic signed [DOT_W-1:0]   target_dot_reg, target_dot_next;
    logic [CNT_W-1:0]          slice_count_reg, slice_count_next;
    logic [SLICE_W-1:0]        slice_time_reg, slice_time_next;

    logic                      accept;
    action_t                   action_in;
    pattern_t                  pattern_in;
    logic signed [DIGIT_W-1:0] num_in, num_c, roll_digit;
    logic signed [DOT_W-1:0]   dot_in, dot_c, roll_dot;
    logic [DUR_W-1:0]          dur_in;
    logic [WAIT_W-1:0]         dur_us;
    logic [PROD_W-1:0]         cur_prod, nxt_prod;
    logic [WAIT_W-1:0]         cur_wait, nxt_wait;
    logic signed [DIGIT_W-1:0] cn, nn;
    logic signed [DOT_W-1:0]   cd, nd;
    logic [MAX_CMDS-1:0][$bits(cmd_t)-1:0] cmds_raw;
    cmd_t [MAX_CMDS-1:0]       cmds;
    logic [NUM_W-1:0]          cnt;

    localparam logic [CNT_W-1:0] FADE_STEPS_C = CNT_W'(FADE_STEPS);

    assign s_tready   = q_ready;
    assign accept     = s_tvalid && s_tready;
    assign action_in  = action_t'(s_tuser);
    assign pattern_in = pattern_t'(s_tdata[2:0]);
    assign num_in     = signed'(s_tdata[7:3]);
    assign dot_in     = signed'(s_tdata[9:8]);
    assign dur_in     = s_tdata[25:10];

    assign num_c = (num_in < DIGIT_NONE || num_in > DIGIT_MAX) ? DIGIT_NONE : num_in;
    assign dot_c = (dot_in < DOT_NONE) ? DOT_NONE : dot_in;

    assign dur_us   = WAIT_W'(dur_in) * WAIT_W'(US_PER_MS);
    assign cur_prod = PROD_W'(slice_time_reg) * PROD_W'(FADE_STEPS_C - slice_count_reg);
    assign nxt_prod = PROD_W'(slice_time_reg) * PROD_W'(slice_count_reg);
    assign cur_wait = WAIT_W'(cur_prod / FADE_STEPS);
    assign nxt_wait = WAIT_W'(nxt_prod / FADE_STEPS);

    assign roll_digit = (shown_digit_reg >= DIGIT_MAX) ? DIGIT_NONE
                                                       : shown_digit_reg + 5'sd1;
    assign roll_dot   = (shown_dot_reg >= DOT_MAX) ? DOT_NONE : shown_dot_reg + 2'sd1;

    assign cn = (shown_digit_reg == target_digit_reg) ? DIGIT_NONE : shown_digit_reg;
    assign nn = (shown_digit_reg == target_digit_reg) ? DIGIT_NONE : target_digit_reg;
    assign cd = (shown_dot_reg == target_dot_reg) ? DOT_NONE : shown_dot_reg;
    assign nd = (shown_dot_reg == target_dot_reg) ? DOT_NONE : target_dot_reg;

    always_comb
    begin
        pattern_next      = pattern_reg;
        running_next      = running_reg;
        shown_digit_next  = shown_digit_reg;
        target_digit_next = target_digit_reg;
        shown_dot_next    = shown_dot_reg;
        target_dot_next   = target_dot_reg;
        slice_count_next  = slice_count_reg;
        slice_time_next   = slice_time_reg;
        cmds_raw          = '0;
        cnt               = '0;
        if (accept)
        begin
            if (action_in == ACT_START)
            begin
                pattern_next      = pattern_in;
                target_digit_next = num_c;
                target_dot_next   = dot_c;
                slice_time_next   = SLICE_W'(dur_us / FADE_STEPS);
                slice_count_next  = '0;
                running_next      = 1'b1;
                unique case (pattern_in)
                    PAT_OFF:
                    begin
                        cmds_raw[0]      = make_cmd(1'b1, DIGIT_NONE, DOT_NONE, 1'b0, '0);
                        cnt              = NUM_W'(1);
                        shown_digit_next = num_c;
                        shown_dot_next   = dot_c;
                        running_next     = 1'b0;
                    end
                    PAT_CHANGE:
                    begin
                        if (shown_digit_reg != num_c)
                        begin
                            cmds_raw[0] = make_cmd(1'b0, shown_digit_reg, DOT_NONE, 1'b0, '0);
                            if (shown_dot_reg != dot_c)
                            begin
                                cmds_raw[1] = make_cmd(1'b0, DIGIT_NONE, shown_dot_reg,
                                                       1'b0, '0);
                                cnt = NUM_W'(2);
                            end
                            else
                            begin
                                cnt = NUM_W'(1);
                            end
                        end
                        else if (shown_dot_reg != dot_c)
                        begin
                            cmds_raw[0] = make_cmd(1'b0, DIGIT_NONE, shown_dot_reg, 1'b0, '0);
                            cnt         = NUM_W'(1);
                        end
                    end
                    PAT_ROLL:
                    begin
                        cmds_raw[0] = make_cmd(1'b1, DIGIT_NONE, DOT_NONE, 1'b0, '0);
                        cnt         = NUM_W'(1);
                        if (shown_digit_reg == num_c)
                        begin
                            cmds_raw[1] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg,
                                                   1'b1, '0);
                            cnt         = NUM_W'(2);
                        end
                    end
                    default:
                    begin
                        cmds_raw[0]      = make_cmd(1'b1, DIGIT_NONE, DOT_NONE, 1'b0, '0);
                        cnt              = NUM_W'(1);
                        shown_digit_next = num_c;
                        shown_dot_next   = dot_c;
                    end
                endcase
            end
            else if (running_reg)
            begin
                priority if (pattern_reg == PAT_OFF)
                begin
                    running_next = 1'b0;
                end
                else if (pattern_reg == PAT_SHOW)
                begin
                    cmds_raw[0]  = make_cmd(1'b0, shown_digit_reg, shown_dot_reg, 1'b1, '0);
                    cnt          = NUM_W'(1);
                    running_next = 1'b0;
                end
                else if (pattern_reg == PAT_ROLL)
                begin
                    cmds_raw[0] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg, 1'b0, '0);
                    cnt         = NUM_W'(2);
                    if (shown_digit_reg != target_digit_reg)
                    begin
                        cmds_raw[1]      = make_cmd(1'b0, roll_digit, roll_dot, 1'b1,
                                                    ROLL_WAIT_US);
                        shown_digit_next = roll_digit;
                        shown_dot_next   = roll_dot;
                    end
                    else
                    begin
                        cmds_raw[1]      = make_cmd(1'b0, target_digit_reg, target_dot_reg,
                                                    1'b1, '0);
                        shown_digit_next = target_digit_reg;
                        shown_dot_next   = target_dot_reg;
                        running_next     = 1'b0;
                    end
                end
                else if (slice_count_reg >= FADE_STEPS_C)
                begin
                    if (pattern_reg == PAT_CHANGE)
                    begin
                        shown_digit_next = target_digit_reg;
                        shown_dot_next   = target_dot_reg;
                    end
                    running_next = 1'b0;
                end
                else
                begin
                    unique case (pattern_reg)
                        PAT_FADE_IN:
                        begin
                            cmds_raw[0] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg,
                                                   1'b0, cur_wait);
                            cmds_raw[1] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg,
                                                   1'b1, nxt_wait);
                            cnt         = NUM_W'(2);
                        end
                        PAT_FADE_OUT:
                        begin
                            cmds_raw[0] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg,
                                                   1'b1, cur_wait);
                            cmds_raw[1] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg,
                                                   1'b0, nxt_wait);
                            cnt         = NUM_W'(2);
                        end
                        PAT_CHANGE:
                        begin
                            cmds_raw[0] = make_cmd(1'b0, cn, cd, 1'b1, '0);
                            cmds_raw[1] = make_cmd(1'b0, nn, nd, 1'b0, cur_wait);
                            cmds_raw[2] = make_cmd(1'b0, cn, cd, 1'b0, '0);
                            cmds_raw[3] = make_cmd(1'b0, nn, nd, 1'b1, nxt_wait);
                            cnt         = NUM_W'(4);
                        end
                        PAT_FROM_CLOUD:
                        begin
                            cmds_raw[0] = make_cmd(1'b1, DIGIT_NONE, DOT_NONE, 1'b1, cur_wait);
                            cmds_raw[1] = make_cmd(1'b1, DIGIT_NONE, DOT_NONE, 1'b0, '0);
                            cmds_raw[2] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg,
                                                   1'b1, nxt_wait);
                            cnt         = NUM_W'(3);
                        end
                        default:
                        begin
                            cmds_raw[0] = make_cmd(1'b1, DIGIT_NONE, DOT_NONE, 1'b0, '0);
                            cmds_raw[1] = make_cmd(1'b0, shown_digit_reg, shown_dot_reg,
                                                   1'b1, cur_wait);
                            cmds_raw[2] = make_cmd(1'b1, DIGIT_NONE, DOT_NONE, 1'b1, nxt_wait);
                            cnt         = NUM_W'(3);
                        end
                    endcase
                    slice_count_next = slice_count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_CMDS; i++)
        begin
            cmds[i] = cmd_t'(cmds_raw[i]);
        end
    end

    assign batch.cmds  = cmds;
    assign batch.count = cnt;
    assign batch.busy  = running_next;
    assign push        = accept && (cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg      <= PAT_SHOW;
            running_reg      <= 1'b0;
            shown_digit_reg  <= DIGIT_NONE;
            target_digit_reg <= DIGIT_NONE;
            shown_dot_reg    <= DOT_NONE;
            target_dot_reg   <= DOT_NONE;
            slice_count_reg  <= '0;
            slice_time_reg   <= '0;
        end
        else
        begin
            pattern_reg      <= pattern_next;
            running_reg      <= running_next;
            shown_digit_reg  <= shown_digit_next;
            target_digit_reg <= target_digit_next;
            shown_dot_reg    <= shown_dot_next;
            target_dot_reg   <= target_dot_next;
            slice_count_reg  <= slice_count_next;
            slice_time_reg   <= slice_time_next;
        end
    end

endmodule
`default_nettype wire

### rtl/nts_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nts_queue
// Two-entry queue of command batches between the front and the back.
// ---------------------------------------------------------------------------
module nts_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire nts_pkg::batch_t wr_batch,
    output logic                 wr_ready,
    input  wire logic            pop,
    output nts_pkg::batch_t      rd_batch,
    output logic                 rd_valid
);
    import nts_pkg::*;

    batch_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign do_push  = push && wr_ready;
    assign do_pop   = pop && rd_valid;
    assign rd_batch = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_batch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

### rtl/nts_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nts_back
// Takes batches from the queue and sends their commands one beat a cycle,
// while m_tready is high, through a registered output stage.
// ---------------------------------------------------------------------------
module nts_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire nts_pkg::batch_t q_batch,
    input  wire logic            q_valid,
    output logic                 pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output nts_pkg::cmd_t        m_cmd,
    output logic                 m_last,
    output logic                 m_busy
);
    import nts_pkg::*;

    batch_t           cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    cmd_t             out_cmd_reg, out_cmd_next;
    logic             out_last_reg, out_last_next;
    logic             out_busy_reg, out_busy_next;
    logic             load, last_cmd;

    assign load     = cur_valid_reg && (!out_valid_reg || m_tready);
    assign last_cmd = ({1'b0, idx_reg} == (cur_reg.count - NUM_W'(1)));
    assign pop      = q_valid && (!cur_valid_reg || (load && last_cmd));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_cmd_next   = out_cmd_reg;
        out_last_next  = out_last_reg;
        out_busy_next  = out_busy_reg;
        if (pop)
        begin
            cur_next       = q_batch;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (load && last_cmd)
        begin
            cur_valid_next = 1'b0;
        end
        else if (load)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            out_cmd_next   = cur_reg.cmds[idx_reg];
            out_last_next  = last_cmd;
            out_busy_next  = cur_reg.busy;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        out_cmd_reg  <= out_cmd_next;
        out_last_reg <= out_last_next;
        out_busy_reg <= out_busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_cmd    = out_cmd_reg;
    assign m_last   = out_last_reg;
    assign m_busy   = out_busy_reg;

endmodule
`default_nettype wire

### rtl/nixie_transition_sequencer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nixie_transition_sequencer
// Drives one nixie tube through off, show, fade, change, roll and cloud
// transitions as a stream of cathode commands.
// ---------------------------------------------------------------------------
// A start beat (tuser 0) loads pattern, digit, dot and fade length; each tick
// beat (tuser 1) then yields the commands of one step, zero to four of them,
// the final one marked by tlast. The input side takes one beat per cycle
// while the two-batch queue has room; the output stage sends one command per
// cycle while m_tready is high, each item holding none to four commands, four
// for each cross-fade slice. Fade slices last the fade length times 1000 / 64
// microseconds, split between old and new image by the step count.
module nixie_transition_sequencer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pattern[2:0], number[7:3], dot[9:8], duration_ms[25:10], zero pad
    input  wire logic [31:0] s_tdata,
    // action
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // digit[4:0], dot_sel[6:5], light[7], wait_us[33:8], busy_res[34], zero pad
    output logic [39:0]      m_tdata,
    // target_all
    output logic             m_tuser,
    output logic             m_tlast
);
    import nts_pkg::*;

    logic   push, q_ready, q_valid, pop, out_busy;
    batch_t wr_batch, rd_batch;
    cmd_t   out_cmd;

    nts_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .push     (push),
        .batch    (wr_batch)
    );

    nts_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_batch (wr_batch),
        .wr_ready (q_ready),
        .pop      (pop),
        .rd_batch (rd_batch),
        .rd_valid (q_valid)
    );

    nts_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_batch  (rd_batch),
        .q_valid  (q_valid),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_cmd    (out_cmd),
        .m_last   (m_tlast),
        .m_busy   (out_busy)
    );

    assign m_tdata = {5'b0, out_busy, out_cmd.wait_us, out_cmd.light,
                      out_cmd.dot_sel, out_cmd.digit};
    assign m_tuser = out_cmd.target_all;

    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("command burst broken before its last beat");

    a_all_addr_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[4:0] == 5'h1F) && (m_tdata[6:5] == 2'h3))
        else $error("all-cathode command carries a digit or dot");

    a_batch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> rd_batch.count != '0)
        else $error("empty batch queued");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_ready)
        else $error("batch pushed into full queue");

endmodule
`default_nettype wire
